>>> src/fvn_pkg.sv
package fvn_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned SeedW    = 32;
  localparam int unsigned LevelW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CountW   = 4;
  // effective octave count, wide enough for sixteen octaves
  localparam int unsigned OctW     = 5;
  localparam int unsigned FreqW    = 32;
  localparam int unsigned AmpW     = 17;
  localparam int unsigned NormW    = 21;
  localparam int unsigned ValW     = 24;
  localparam int unsigned SumW     = 45;
  localparam int unsigned WgtW     = 17;

  localparam logic [31:0] HashMulX = 32'h8da6b343;
  localparam logic [31:0] HashMulY = 32'hd8163841;
  localparam logic [31:0] HashMulS = 32'hcb1ab31f;
  localparam logic [31:0] HashMulA = 32'h7feb352d;
  localparam logic [31:0] HashMulB = 32'h846ca68b;
  localparam logic [31:0] SeedStep = 32'd1013;

  localparam logic [FreqW-1:0] FreqOne = 32'd4096;
  localparam logic [AmpW-1:0]  AmpOne  = 17'd65536;
  localparam logic [WgtW-1:0]  WgtOne  = 17'd65536;
  localparam logic [41:0]      ContrastBias = 42'h8_0000_0000;

  localparam logic [CountW-1:0]   RstOctaveCount = 4'd4;
  localparam logic [CfgDataW-1:0] RstLacunarity  = 16'd8192;
  localparam logic [CfgDataW-1:0] RstOctaveGain  = 16'd32768;
  localparam logic [CfgDataW-1:0] RstContrast    = 16'd7373;

  typedef enum logic [CfgIdxW-1:0] {
    RegOctaveCount = 2'd0,
    RegLacunarity  = 2'd1,
    RegOctaveGain  = 2'd2,
    RegContrast    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CoordW-1:0] x_coord;
    logic [CoordW-1:0] y_coord;
    logic [SeedW-1:0]  seed;
    logic [FreqW-1:0]  freq;
    logic [AmpW-1:0]   amp;
    logic [SumW-1:0]   sum;
    logic [NormW-1:0]  norm;
  } ctx_t;

  typedef struct packed {
    logic [CfgDataW-1:0] lacunarity;
    logic [CfgDataW-1:0] octave_gain;
  } cell_cfg_t;

endpackage

>>> src/fvn_ifs.sv
interface fvn_in_if import fvn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [CoordW-1:0] x_coord;
  logic signed [CoordW-1:0] y_coord;
  logic [SeedW-1:0]  noise_seed;

  modport source (output valid, output x_coord, output y_coord, output noise_seed,
                  input ready);
  modport sink (input valid, input x_coord, input y_coord, input noise_seed,
                output ready);
endinterface

interface fvn_out_if import fvn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] level;

  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

interface fvn_cfg_if import fvn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/fvn_cell.sv
module fvn_cell import fvn_pkg::*; #(
  parameter int unsigned Index    = 0,
  parameter int unsigned FracBits = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      active_i,
  input  cell_cfg_t cfg_i,
  input  logic      vld_i,
  input  ctx_t      ctx_i,
  output logic      vld_o,
  output ctx_t      ctx_o
);

  localparam int unsigned Depth = 9;
  localparam logic [31:0] SeedOfs = 32'(Index) * SeedStep;

  // context delay line, entry s lines up with stage s
  logic [Depth-1:0] vld_q;
  ctx_t             ctx_q [Depth];
  logic             out_vld_q;
  ctx_t             out_ctx_q;

  // stage a: magnitude times frequency
  logic [31:0] magx, magy;
  logic        negx_q, negy_q;
  logic [63:0] prodx_d, prody_d, prodx_q, prody_q;

  // stage b: signed scaled coordinates split into lattice and fraction
  logic [63:0] px, py, sx, sy;
  logic [31:0] x0_d, y0_d, x0_q, y0_q;
  logic [15:0] tx_d, ty_d, tx_q, ty_q;

  // stage c
  logic [31:0] mx_d, my_d, ms_d, mx_q, my_q, ms_q;
  logic [31:0] sqx, sqy;
  logic [15:0] t2x_q, t2y_q, txc_q, tyc_q;

  // stages d to g: hash rounds
  logic [31:0]     hd_d [4];
  logic [31:0]     hd_q [4];
  logic [31:0]     he_d [4];
  logic [31:0]     he_q [4];
  logic [31:0]     hf_d [4];
  logic [31:0]     hf_q [4];
  logic [ValW-1:0] cv_d [4];
  logic [ValW-1:0] cv_q [4];
  logic [33:0]     wpx, wpy;
  logic [WgtW-1:0] wx_d, wy_d;
  logic [WgtW-1:0] wx_dq, wx_eq, wx_fq, wx_gq;
  logic [WgtW-1:0] wy_dq, wy_eq, wy_fq, wy_gq, wy_hq;

  // stages h and i: bilinear blend
  logic [40:0]     l0s, l1s, ns;
  logic [ValW-1:0] lh0_q, lh1_q, n_q;

  // stage j: when active, accumulate and step frequency and amplitude
  ctx_t        ctx_j, ctx_n;
  logic [47:0] nfp;
  logic [32:0] ap;
  logic [40:0] contrib;

  assign magx    = ctx_i.x_coord[31] ? (~ctx_i.x_coord + 32'd1) : ctx_i.x_coord;
  assign magy    = ctx_i.y_coord[31] ? (~ctx_i.y_coord + 32'd1) : ctx_i.y_coord;
  assign prodx_d = 64'(magx) * 64'(ctx_i.freq);
  assign prody_d = 64'(magy) * 64'(ctx_i.freq);

  assign px   = negx_q ? (~prodx_q + 64'd1) : prodx_q;
  assign py   = negy_q ? (~prody_q + 64'd1) : prody_q;
  assign sx   = negx_q ? {12'hfff, px[63:12]} : {12'h000, px[63:12]};
  assign sy   = negy_q ? {12'hfff, py[63:12]} : {12'h000, py[63:12]};
  assign x0_d = sx[FracBits +: 32];
  assign y0_d = sy[FracBits +: 32];

  if (FracBits >= 16) begin : g_frac_trunc
    assign tx_d = sx[FracBits-1 -: 16];
    assign ty_d = sy[FracBits-1 -: 16];
  end else begin : g_frac_pad
    assign tx_d = {sx[FracBits-1:0], {(16-FracBits){1'b0}}};
    assign ty_d = {sy[FracBits-1:0], {(16-FracBits){1'b0}}};
  end

  assign mx_d = x0_q * HashMulX;
  assign my_d = y0_q * HashMulY;
  assign ms_d = (ctx_q[1].seed + SeedOfs) * HashMulS;
  assign sqx  = 32'(tx_q) * 32'(tx_q);
  assign sqy  = 32'(ty_q) * 32'(ty_q);

  // corner c: bit 0 steps x, bit 1 steps y; (x+1)*k equals x*k + k
  always_comb begin
    logic [31:0] hx, hy, hv;
    for (int c = 0; c < 4; c++) begin
      hx = c[0] ? (mx_q + HashMulX) : mx_q;
      hy = c[1] ? (my_q + HashMulY) : my_q;
      hv = hx ^ hy ^ ms_q;
      hd_d[c] = hv ^ (hv >> 16);
    end
  end

  // smoothstep weight t*t*(3-2t)
  assign wpx  = 34'(t2x_q) * (34'(18'h30000) - 34'({txc_q, 1'b0}));
  assign wpy  = 34'(t2y_q) * (34'(18'h30000) - 34'({tyc_q, 1'b0}));
  assign wx_d = wpx[32:16];
  assign wy_d = wpy[32:16];

  always_comb begin
    logic [31:0] tf, tg;
    for (int c = 0; c < 4; c++) begin
      he_d[c] = hd_q[c] * HashMulA;
      tf      = he_q[c] ^ (he_q[c] >> 15);
      hf_d[c] = tf * HashMulB;
      tg      = hf_q[c] ^ (hf_q[c] >> 16);
      cv_d[c] = tg[31:8];
    end
  end

  assign l0s = 41'(cv_q[0]) * 41'(WgtOne - wx_gq) + 41'(cv_q[1]) * 41'(wx_gq);
  assign l1s = 41'(cv_q[2]) * 41'(WgtOne - wx_gq) + 41'(cv_q[3]) * 41'(wx_gq);
  assign ns  = 41'(lh0_q) * 41'(WgtOne - wy_hq) + 41'(lh1_q) * 41'(wy_hq);

  assign ctx_j   = ctx_q[Depth-1];
  assign nfp     = 48'(ctx_j.freq) * 48'(cfg_i.lacunarity);
  assign ap      = 33'(ctx_j.amp) * 33'(cfg_i.octave_gain);
  assign contrib = 41'(n_q) * 41'(ctx_j.amp);

  always_comb begin
    ctx_n = ctx_j;
    if (active_i) begin
      ctx_n.sum  = ctx_j.sum + SumW'(contrib);
      ctx_n.norm = ctx_j.norm + NormW'(ctx_j.amp);
      ctx_n.freq = (nfp[47:44] != 4'd0) ? '1 : nfp[43:12];
      ctx_n.amp  = ap[32:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[Depth-2:0], vld_i};
      out_vld_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q[0] <= ctx_i;
      for (int s = 1; s < Depth; s++) begin
        ctx_q[s] <= ctx_q[s-1];
      end
      negx_q  <= ctx_i.x_coord[31];
      negy_q  <= ctx_i.y_coord[31];
      prodx_q <= prodx_d;
      prody_q <= prody_d;
      x0_q    <= x0_d;
      y0_q    <= y0_d;
      tx_q    <= tx_d;
      ty_q    <= ty_d;
      mx_q    <= mx_d;
      my_q    <= my_d;
      ms_q    <= ms_d;
      t2x_q   <= sqx[31:16];
      t2y_q   <= sqy[31:16];
      txc_q   <= tx_q;
      tyc_q   <= ty_q;
      hd_q    <= hd_d;
      he_q    <= he_d;
      hf_q    <= hf_d;
      cv_q    <= cv_d;
      wx_dq   <= wx_d;
      wx_eq   <= wx_dq;
      wx_fq   <= wx_eq;
      wx_gq   <= wx_fq;
      wy_dq   <= wy_d;
      wy_eq   <= wy_dq;
      wy_fq   <= wy_eq;
      wy_gq   <= wy_fq;
      wy_hq   <= wy_gq;
      lh0_q   <= l0s[39:16];
      lh1_q   <= l1s[39:16];
      n_q     <= ns[39:16];
      out_ctx_q <= ctx_n;
    end
  end

  assign vld_o = out_vld_q;
  assign ctx_o = out_ctx_q;

endmodule

>>> src/fvn_div.sv
module fvn_div import fvn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [SumW-1:0]  sum_i,
  input  logic [NormW-1:0] norm_i,
  output logic             vld_o,
  output logic [ValW-1:0]  mean_o
);

  // one quotient bit per stage, most significant first
  logic [ValW-1:0]  vld_q;
  logic [SumW-1:0]  rem_q [ValW];
  logic [NormW-1:0] den_q [ValW];
  logic [ValW-1:0]  quo_q [ValW];

  for (genvar s = 0; s < ValW; s++) begin : g_stage
    localparam int unsigned Bit = ValW - 1 - s;
    logic             vin;
    logic [SumW-1:0]  rem_in, dsh;
    logic [NormW-1:0] den_in;
    logic [ValW-1:0]  quo_in;
    logic             take;

    if (s == 0) begin : g_head
      assign vin    = vld_i;
      assign rem_in = sum_i;
      assign den_in = norm_i;
      assign quo_in = '0;
    end else begin : g_body
      assign vin    = vld_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign dsh  = SumW'(den_in) << Bit;
    assign take = rem_in >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? (rem_in - dsh) : rem_in;
        den_q[s] <= den_in;
        quo_q[s] <= quo_in | (take ? (ValW'(1) << Bit) : '0);
      end
    end
  end

  assign vld_o  = vld_q[ValW-1];
  assign mean_o = quo_q[ValW-1];

endmodule

>>> src/fbm_value_noise_2d.sv
// channel  | dir | payload                               | note
// in_ch_i  | in  | x_coord, y_coord (Q16.16), noise_seed  | one beat per sample point
// out_ch_o | out | level (Q0.16)                          | one beat per input beat
// cfg_ch_i | in  | index, data                           | register write, always ready
//
// a new point can enter every cycle unless the chain stalls; a point passes each of the
// MAX_OCTAVES octave cells, then the 24 divider stages, then the contrast and output registers
// the octave cells, divider and contrast stages move together on one enable
// the chain stalls only when the output register holds an untaken beat and
// another finished beat waits right behind it; bubbles in front still close up
// reset clears the registers to their documented values and empties the chain
module fbm_value_noise_2d import fvn_pkg::*; #(
  parameter int unsigned MAX_OCTAVES   = 8,
  parameter int unsigned FRACTION_BITS = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  fvn_in_if.sink    in_ch_i,
  fvn_out_if.source out_ch_o,
  fvn_cfg_if.sink   cfg_ch_i
);

  // configuration registers
  logic [CountW-1:0]   octave_count_q;
  logic [CfgDataW-1:0] lacunarity_q;
  logic [CfgDataW-1:0] octave_gain_q;
  logic [CfgDataW-1:0] contrast_gain_q;
  logic [OctW-1:0]     oct_eff;
  cell_cfg_t           cell_cfg;

  // octave chain
  logic [MAX_OCTAVES:0] chain_vld;
  ctx_t                 chain_ctx [MAX_OCTAVES+1];

  // divider and contrast
  logic             div_vld;
  logic [ValW-1:0]  mean;
  logic             p1_vld_q;
  logic [39:0]      cprod_q;
  logic [41:0]      val;
  logic [LevelW-1:0] level_d, level_q;
  logic             out_vld_q;
  logic             en;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_count_q  <= RstOctaveCount;
      lacunarity_q    <= RstLacunarity;
      octave_gain_q   <= RstOctaveGain;
      contrast_gain_q <= RstContrast;
    end else if (cfg_ch_i.valid) begin
      unique case (reg_idx_e'(cfg_ch_i.index))
        RegOctaveCount: octave_count_q  <= cfg_ch_i.data[CountW-1:0];
        RegLacunarity:  lacunarity_q    <= cfg_ch_i.data;
        RegOctaveGain:  octave_gain_q   <= cfg_ch_i.data;
        RegContrast:    contrast_gain_q <= cfg_ch_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_ch_i.ready = 1'b1;

  // zero octaves means one, too many is capped at the number of cells
  always_comb begin
    priority if (octave_count_q == '0) begin
      oct_eff = OctW'(1);
    end else if (OctW'(octave_count_q) > OctW'(MAX_OCTAVES)) begin
      oct_eff = OctW'(MAX_OCTAVES);
    end else begin
      oct_eff = OctW'(octave_count_q);
    end
  end

  assign cell_cfg.lacunarity  = lacunarity_q;
  assign cell_cfg.octave_gain = octave_gain_q;

  // whole pipe advances unless a finished beat would collide with a held one
  assign en            = !(out_vld_q && !out_ch_o.ready && p1_vld_q);
  assign in_ch_i.ready = en;

  // first octave: frequency 1.0, amplitude 1.0, empty sums
  assign chain_vld[0]         = in_ch_i.valid;
  assign chain_ctx[0].x_coord = in_ch_i.x_coord;
  assign chain_ctx[0].y_coord = in_ch_i.y_coord;
  assign chain_ctx[0].seed    = in_ch_i.noise_seed;
  assign chain_ctx[0].freq    = FreqOne;
  assign chain_ctx[0].amp     = AmpOne;
  assign chain_ctx[0].sum     = '0;
  assign chain_ctx[0].norm    = '0;

  // one cell per octave; cells past the octave count pass the beat unchanged
  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    fvn_cell #(
      .Index    (k),
      .FracBits (FRACTION_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .active_i (OctW'(k) < oct_eff),
      .cfg_i    (cell_cfg),
      .vld_i    (chain_vld[k]),
      .ctx_i    (chain_ctx[k]),
      .vld_o    (chain_vld[k+1]),
      .ctx_o    (chain_ctx[k+1])
    );
  end

  // weighted mean: sum over sum of weights
  fvn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (chain_vld[MAX_OCTAVES]),
    .sum_i  (chain_ctx[MAX_OCTAVES].sum),
    .norm_i (chain_ctx[MAX_OCTAVES].norm),
    .vld_o  (div_vld),
    .mean_o (mean)
  );

  // contrast about one half: mean*c - half*c + half<<12, all Q6.36
  assign val = {2'b00, cprod_q} - {3'b000, contrast_gain_q, 23'd0} + ContrastBias;

  always_comb begin
    priority if (val[41] || (val == '0)) begin
      level_d = '0;
    end else if (val[40:36] != '0) begin
      level_d = '1;
    end else begin
      level_d = val[35:20];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en) begin
        p1_vld_q <= div_vld;
      end
      if (out_vld_q && out_ch_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (en && p1_vld_q) begin
        out_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cprod_q <= 40'(mean) * 40'(contrast_gain_q);
    end
    if (en && p1_vld_q) begin
      level_q <= level_d;
    end
  end

  assign out_ch_o.valid = out_vld_q;
  assign out_ch_o.level = level_q;

`ifndef SYNTH
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_ch_i.ready)
    else $error("input stalled with an empty output register");

  a_oct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oct_eff != '0) && (oct_eff <= OctW'(MAX_OCTAVES)))
    else $error("effective octave count out of range");

  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_vld[MAX_OCTAVES] |-> (chain_ctx[MAX_OCTAVES].norm != '0))
    else $error("weight sum zero at divider entry");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && p1_vld_q) |=> out_vld_q)
    else $error("finished beat not loaded into output register");
`endif

endmodule

>>> tb/testbench.sv
module testbench;
  import fvn_pkg::*;

  // clock, reset and the three channels
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fvn_in_if  in_ch();
  fvn_out_if out_ch();
  fvn_cfg_if cfg_ch();

  fbm_value_noise_2d u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch.sink),
    .out_ch_o (out_ch.source),
    .cfg_ch_i (cfg_ch.sink)
  );

  always #10 clk_i = ~clk_i;

  localparam int unsigned DrainCycles = 130; // time to run through the octave cells, divider, contrast
  localparam int unsigned HoldCycles  = 400; // long receiver hold-off to fill the chain

  // idling modes
  localparam int unsigned IdleNone = 0;
  localparam int unsigned IdleSend = 1;
  localparam int unsigned IdleRecv = 2;
  localparam int unsigned IdleBoth = 3;

  // local copy of the register file
  logic [CountW-1:0]   octaves_q  = RstOctaveCount;
  logic [CfgDataW-1:0] lacun_q    = RstLacunarity;
  logic [CfgDataW-1:0] gain_q     = RstOctaveGain;
  logic [CfgDataW-1:0] contrast_q = RstContrast;

  logic [LevelW-1:0] level_q[$]; // expected levels, oldest first
  int unsigned mismatches = 0;
  int unsigned idle_mode  = IdleNone;
  int unsigned hold_left  = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] corner_hash(logic [31:0] cx, logic [31:0] cy,
                                              logic [31:0] sd);
    logic [31:0] h;
    h = (cx * HashMulX) ^ (cy * HashMulY) ^ (sd * HashMulS);
    h = h ^ (h >> 16);
    h = h * HashMulA;
    h = h ^ (h >> 15);
    h = h * HashMulB;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // cubic ease of a Q0.16 fraction
  function automatic logic [63:0] ease(logic [15:0] t);
    logic [63:0] t2;
    t2 = (64'(t) * 64'(t)) >> 16;
    return (t2 * (64'd196608 - 64'(2 * 64'(t)))) >> 16;
  endfunction

  function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] w);
    return (a * (64'd65536 - w) + b * w) >> 16;
  endfunction

  // one octave: bilinear blend of the four lattice corners, Q0.24
  function automatic logic [63:0] cell_value(longint sx, longint sy, logic [31:0] sd);
    logic [31:0] x0, y0;
    logic [63:0] u, v, a, b, c, d;
    x0 = sx[47:16];
    y0 = sy[47:16];
    u = ease(sx[15:0]);
    v = ease(sy[15:0]);
    a = 64'(corner_hash(x0, y0, sd) >> 8);
    b = 64'(corner_hash(x0 + 32'd1, y0, sd) >> 8);
    c = 64'(corner_hash(x0, y0 + 32'd1, sd) >> 8);
    d = 64'(corner_hash(x0 + 32'd1, y0 + 32'd1, sd) >> 8);
    return mix(mix(a, b, u), mix(c, d, u), v);
  endfunction

  function automatic logic [LevelW-1:0] fbm_level(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] sd);
    int unsigned cnt;
    logic [31:0] freq;
    logic [63:0] amp, sum, norm, nf, mean;
    longint sx, sy, val;
    cnt = 32'(octaves_q);
    if (cnt == 0) cnt = 1;
    if (cnt > 8) cnt = 8;
    freq = FreqOne;
    amp  = 64'd65536;
    sum  = 0;
    norm = 0;
    for (int unsigned i = 0; i < cnt; i++) begin
      // floor(coord*freq/4096); arithmetic shift floors negatives
      sx = (longint'($signed(x)) * longint'({32'b0, freq})) >>> 12;
      sy = (longint'($signed(y)) * longint'({32'b0, freq})) >>> 12;
      sum  = sum + cell_value(sx, sy, sd + i * SeedStep) * amp;
      norm = norm + amp;
      nf   = (64'(freq) * 64'(lacun_q)) >> 12;
      freq = (nf > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nf[31:0];
      amp  = (amp * 64'(gain_q)) >> 16;
    end
    mean = sum / norm;
    val = longint'(mean) * longint'(contrast_q) - 64'sd8388608 * longint'(contrast_q)
        + (64'sd8388608 <<< 12);
    if (val <= 0) return '0;
    val = val >>> 20;
    return (val > 65535) ? 16'hFFFF : val[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // drivers: inputs change on the falling edge
  // ---------------------------------------------------------------------------

  function automatic bit sender_rests();
    if (idle_mode == IdleSend) return $urandom_range(99) < 83;
    if (idle_mode == IdleBoth) return $urandom_range(99) < 15;
    return 1'b0;
  endfunction

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_mode == IdleRecv) begin
      out_ch.ready <= $urandom_range(99) >= 83;
    end else if (idle_mode == IdleBoth) begin
      out_ch.ready <= $urandom_range(99) >= 15;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] sd,
                            bit typed, logic [LevelW-1:0] lvl);
    while (sender_rests()) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      = 1'b1;
    in_ch.x_coord    = x;
    in_ch.y_coord    = y;
    in_ch.noise_seed = sd;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    level_q.push_back(typed ? lvl : fbm_level(x, y, sd));
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  // register write, only with the chain empty
  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      RegOctaveCount: octaves_q  = data[CountW-1:0];
      RegLacunarity:  lacun_q    = data;
      RegOctaveGain:  gain_q     = data;
      default:        contrast_q = data;
    endcase
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (level_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // checker: outputs sampled on the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (level_q.size() == 0) begin
        $display("%0t: level beat with nothing expected, actual %0d", $time, out_ch.level);
        mismatches++;
      end else if (out_ch.level !== level_q[0]) begin
        $display("%0t: level expected %0d actual %0d", $time, level_q[0], out_ch.level);
        mismatches++;
        void'(level_q.pop_front());
      end else begin
        void'(level_q.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed plan
  // ---------------------------------------------------------------------------

  typedef struct {
    bit                is_write;
    reg_idx_e          idx;
    logic [CfgDataW-1:0] data;
    logic [31:0]       x, y, sd;
    bit                typed;
    logic [LevelW-1:0] lvl;
  } step_t;

  step_t plan[$];

  function automatic step_t wr(reg_idx_e idx, logic [CfgDataW-1:0] data);
    step_t s;
    s = '{1'b1, idx, data, '0, '0, '0, 1'b0, '0};
    return s;
  endfunction

  function automatic step_t pt(logic [31:0] x, logic [31:0] y, logic [31:0] sd,
                               bit typed = 1'b0, logic [LevelW-1:0] lvl = '0);
    step_t s;
    s = '{1'b0, RegOctaveCount, '0, x, y, sd, typed, lvl};
    return s;
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    if ($urandom_range(9) < 6) return $urandom();
    // near the origin, fine fraction detail, either sign
    c = $urandom_range(32'h7_FFFF);
    return $urandom_range(1) ? -c : c;
  endfunction

  function automatic logic [CfgDataW-1:0] rand_word(int unsigned ph, int unsigned lo_ph,
                                                    int unsigned hi_ph);
    if (ph == lo_ph) return '0;
    if (ph == hi_ph) return '1;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    in_ch.noise_seed = '0;
    out_ch.ready = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = RegOctaveCount;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings, field extremes
    plan.push_back(pt(32'h0, 32'h0, 32'h0));
    plan.push_back(pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    plan.push_back(pt(32'h8000_0000, 32'h8000_0000, 32'h1234_5678));
    plan.push_back(pt(32'h7FFF_FFFF, 32'h8000_0000, 32'hA5A5_5A5A));
    // lattice wrap just below zero
    plan.push_back(pt(32'hFFFF_FFFF, 32'hFFFF_8000, 32'h0000_0001));
    // contrast zero pins everything to mid grey
    plan.push_back(wr(RegContrast, 16'd0));
    plan.push_back(pt(32'h1234_5678, 32'h9ABC_DEF0, 32'hDEAD_BEEF, 1'b1, 16'd32768));
    plan.push_back(pt(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'd32768));
    // contrast overshoot clamps both ends
    plan.push_back(wr(RegContrast, 16'hFFFF));
    plan.push_back(pt(32'h0001_8000, 32'h0002_4000, 32'h0000_0007));
    plan.push_back(pt(32'hFFF3_0000, 32'h0000_C000, 32'h0000_0BAD));
    // octave count zero and above the maximum
    plan.push_back(wr(RegOctaveCount, 16'd0));
    plan.push_back(pt(32'h0003_1234, 32'h0005_4321, 32'h0000_0042));
    plan.push_back(wr(RegOctaveCount, 16'd15));
    plan.push_back(pt(32'h0003_1234, 32'h0005_4321, 32'h0000_0042));
    // frequency saturation with maximal lacunarity
    plan.push_back(wr(RegLacunarity, 16'hFFFF));
    plan.push_back(pt(32'h7FFF_FFFF, 32'h8000_0001, 32'h0F0F_0F0F));
    // lacunarity zero, later octaves at the lattice origin
    plan.push_back(wr(RegLacunarity, 16'd0));
    plan.push_back(pt(32'h0042_8000, 32'hFFBE_4000, 32'h0000_0099));
    // gain zero, only the first octave counts
    plan.push_back(wr(RegOctaveGain, 16'd0));
    plan.push_back(pt(32'h0042_8000, 32'hFFBE_4000, 32'h0000_0099));
    plan.push_back(wr(RegOctaveGain, 16'hFFFF));
    plan.push_back(wr(RegContrast, RstContrast));
    plan.push_back(pt(32'h0000_FFFF, 32'hFFFF_0001, 32'h8000_0000));

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_point(plan[i].x, plan[i].y, plan[i].sd, plan[i].typed, plan[i].lvl);
      end
    end

    // random phases, each with its own settings and idling mode
    for (int unsigned ph = 0; ph < 10; ph++) begin
      drain();
      write_reg(RegOctaveCount, (ph == 8) ? 16'd8 : (ph == 9) ? 16'd1
                                : 16'($urandom_range(15)));
      write_reg(RegLacunarity, rand_word(ph, 1, 2));
      write_reg(RegOctaveGain, rand_word(ph, 3, 5));
      write_reg(RegContrast, rand_word(ph, 6, 7));
      idle_mode = ph % 4;
      // receiver holds off while more points come than the chain can hold
      if (ph == 4) hold_left = HoldCycles;
      repeat ((ph == 4) ? 160 : 86) send_point(rand_coord(), rand_coord(), $urandom(),
                                               1'b0, '0);
    end
    idle_mode = IdleNone;
    drain();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
